[sv/pmg_pkg.sv]
package pmg_pkg;

    // Width of the internal cursor coordinates.
    localparam int COORD_BITS = 11;
    localparam int LIMIT_BITS = 11;
    localparam int DELAY_BITS = 16;
    localparam int BAR_BITS   = 8;
    localparam int TICK_BITS  = 32;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;

    // Signed working width for position sums, clamps and compares.
    localparam int SUM_W = ((COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS) + 2;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    localparam logic [LIMIT_BITS-1:0] X_LIMIT_RESET = LIMIT_BITS'(790);
    localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RESET = LIMIT_BITS'(590);
    localparam logic [DELAY_BITS-1:0] DELAY_RESET   = DELAY_BITS'(20);
    localparam logic [BAR_BITS-1:0]   BAR_RESET     = BAR_BITS'(20);
    localparam logic [TICK_BITS-1:0]  LAST_CLICK_RESET = TICK_BITS'(32'hFFFF_FFEC);

    // Header byte bits.
    localparam int HDR_LEFT  = 0;
    localparam int HDR_RIGHT = 1;
    localparam int HDR_ZERO  = 2;
    localparam int HDR_ONE   = 3;
    localparam int HDR_XNEG  = 4;
    localparam int HDR_YNEG  = 5;

    localparam logic [7:0] BIG_POS_BYTE = 8'd127;  // +127
    localparam logic [7:0] BIG_NEG_BYTE = 8'd129;  // low byte of -127 as a nine-bit value

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_X_LIMIT   = 2'd0,
        CFG_Y_LIMIT   = 2'd1,
        CFG_DC_DELAY  = 2'd2,
        CFG_BAR_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_MOVE   = 3'd0,
        KIND_LEFT   = 3'd1,
        KIND_RIGHT  = 3'd2,
        KIND_DOUBLE = 3'd3,
        KIND_DRAG   = 3'd4,
        KIND_NONE   = 3'd5
    } kind_t;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] x_limit;
        logic [LIMIT_BITS-1:0] y_limit;
        logic [DELAY_BITS-1:0] dc_delay;
        logic [BAR_BITS-1:0]   bar_height;
    } cfg_t;

    // One command from the framing side to the position and button side.
    typedef struct packed {
        logic                  is_y;
        logic                  neg;
        logic [7:0]            move;
        logic                  left;
        logic                  right;
        logic [TICK_BITS-1:0]  tick;
        logic [LIMIT_BITS-1:0] top;
    } cmd_t;

    // Clamp a signed sum to 0..limit, the limit saturated to the coordinate range.
    function automatic logic [COORD_BITS-1:0] clamp_pos(
        input logic signed [SUM_W-1:0] v,
        input logic [LIMIT_BITS-1:0]   lim
    );
        logic signed [SUM_W-1:0] lim_ext;
        logic signed [SUM_W-1:0] max_ext;
        logic signed [SUM_W-1:0] res;
        lim_ext = $signed({{(SUM_W-LIMIT_BITS){1'b0}}, lim});
        max_ext = $signed({{(SUM_W-COORD_BITS){1'b0}}, COORD_MAX});
        if (lim_ext > max_ext)
            lim_ext = max_ext;
        if (v < 0)
            res = '0;
        else if (v > lim_ext)
            res = lim_ext;
        else
            res = v;
        return res[COORD_BITS-1:0];
    endfunction

    // Cursor position as seen on the output fields.
    function automatic logic [LIMIT_BITS-1:0] to_field(input logic [COORD_BITS-1:0] p);
        logic [SUM_W-1:0] tmp;
        tmp = {{(SUM_W-COORD_BITS){1'b0}}, p};
        return tmp[LIMIT_BITS-1:0];
    endfunction

endpackage

[sv/ps2_mouse_gesture_decoder_top.sv]
// PS/2 mouse packet decoder with click, double click and title bar drag detection.
//
// Input channel: one beat per controller read, carrying data_ready, data_byte,
// the current tick count and the top edge of the window under the cursor. A
// beat moves when in_valid is high and in_stall is low. Three data beats
// (header, X move, Y move) make one packet; reads without data resynchronize
// to the header, and the first data byte after reset is thrown away unless such
// a read came first. Output channel: one beat per completed packet, unless the
// packet held a large move, carrying the message kind and the clamped cursor
// position. A beat moves when out_valid is high and out_stall is low.
// Throughput is one input beat per cycle while the queue has room: the framing
// logic hands X and Y bytes through a two-entry queue to the position and
// button logic, which retires one entry per cycle unless a Y entry waits for
// the output register. A Y byte's result goes via the queue to that register.
// When out_stall holds, the finished beat waits there; X bytes keep draining,
// and once the queue fills in_stall rises. Reset clears the framing phase, the
// queue, the button state and the cursor and loads the register defaults; the
// user must write configuration only while idle; the block does not enforce it.
module ps2_mouse_gesture_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          data_ready,
    input  logic [7:0]                    data_byte,
    input  logic [31:0]                   tick_now,
    input  logic [10:0]                   window_top_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    message_kind,
    output logic [10:0]                   cursor_x,
    output logic [10:0]                   cursor_y,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [pmg_pkg::CFG_BITS-1:0]  cfg_data
);
    import pmg_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic queue_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // The front stalls only when the queue has no room.
    assign in_stall = queue_full;

    // Configuration registers; each write takes the low bits of the data word.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_X_LIMIT:    cfg_next.x_limit    = cfg_data[LIMIT_BITS-1:0];
                CFG_Y_LIMIT:    cfg_next.y_limit    = cfg_data[LIMIT_BITS-1:0];
                CFG_DC_DELAY:   cfg_next.dc_delay   = cfg_data[DELAY_BITS-1:0];
                CFG_BAR_HEIGHT: cfg_next.bar_height = cfg_data[BAR_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.x_limit    <= X_LIMIT_RESET;
            cfg_reg.y_limit    <= Y_LIMIT_RESET;
            cfg_reg.dc_delay   <= DELAY_RESET;
            cfg_reg.bar_height <= BAR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Framing: phase tracking, header checks and header bit capture.
    pmg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .queue_full   (queue_full),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .tick_now     (tick_now),
        .window_top_y (window_top_y),
        .push         (push),
        .cmd          (push_cmd)
    );

    pmg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Cursor update, button tracking and the output register.
    pmg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .message_kind (message_kind),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y)
    );

endmodule

[sv/pmg_front.sv]
module pmg_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          queue_full,
    input  logic          data_ready,
    input  logic [7:0]    data_byte,
    input  logic [31:0]   tick_now,
    input  logic [10:0]   window_top_y,
    output logic          push,
    output pmg_pkg::cmd_t cmd
);
    import pmg_pkg::*;

    typedef enum logic [3:0] {
        PH_DISCARD = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_X       = 4'b0100,
        PH_Y       = 4'b1000
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   left_reg, left_next;
    logic   right_reg, right_next;
    logic   xneg_reg, xneg_next;
    logic   yneg_reg, yneg_next;
    logic   accept;
    logic   header_ok;

    assign accept    = in_valid && !queue_full;
    assign header_ok = data_byte[HDR_ONE] && !data_byte[HDR_ZERO];

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        right_next = right_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        push       = 1'b0;
        if (accept) begin
            if (!data_ready) begin
                phase_next = PH_HEADER;
            end else begin
                unique case (phase_reg)
                    PH_DISCARD: phase_next = PH_HEADER;
                    PH_HEADER:
                    begin
                        if (header_ok) begin
                            left_next  = data_byte[HDR_LEFT];
                            right_next = data_byte[HDR_RIGHT];
                            xneg_next  = data_byte[HDR_XNEG];
                            yneg_next  = data_byte[HDR_YNEG];
                            phase_next = PH_X;
                        end
                    end
                    PH_X:
                    begin
                        push       = 1'b1;
                        phase_next = PH_Y;
                    end
                    PH_Y:
                    begin
                        push       = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    default: phase_next = PH_HEADER;
                endcase
            end
        end
    end

    always_comb
    begin
        cmd.is_y  = (phase_reg == PH_Y);
        cmd.neg   = (phase_reg == PH_Y) ? yneg_reg : xneg_reg;
        cmd.move  = data_byte;
        cmd.left  = left_reg;
        cmd.right = right_reg;
        cmd.tick  = tick_now;
        cmd.top   = window_top_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_DISCARD;
            left_reg  <= 1'b0;
            right_reg <= 1'b0;
            xneg_reg  <= 1'b0;
            yneg_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            xneg_reg  <= xneg_next;
            yneg_reg  <= yneg_next;
        end
    end

endmodule

[sv/pmg_queue.sv]
module pmg_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pmg_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output pmg_pkg::cmd_t head_cmd
);
    import pmg_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/pmg_back.sv]
module pmg_back (
    input  logic          clk,
    input  logic          rst_n,
    input  pmg_pkg::cfg_t cfg,
    input  logic          head_valid,
    input  pmg_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [2:0]    message_kind,
    output logic [10:0]   cursor_x,
    output logic [10:0]   cursor_y
);
    import pmg_pkg::*;

    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic                  xbig_reg, xbig_next;
    logic                  lheld_reg, lheld_next;
    logic                  rheld_reg, rheld_next;
    logic                  drag_reg, drag_next;
    logic [TICK_BITS-1:0]  last_reg, last_next;
    logic                  ovalid_reg, ovalid_next;
    kind_t                 kind_reg, kind_next;
    logic [LIMIT_BITS-1:0] cx_reg, cx_next;
    logic [LIMIT_BITS-1:0] cy_reg, cy_next;

    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [COORD_BITS-1:0]   new_y;
    logic                    big;
    logic [TICK_BITS-1:0]    diff;
    logic                    later;
    logic [SUM_W-1:0]        bar_edge;
    logic [SUM_W-1:0]        new_y_ext;
    kind_t                   kind;
    logic                    slot_free;

    assign slot_free = !ovalid_reg || !out_stall;
    assign pop       = head_valid && (!head_cmd.is_y || slot_free);

    always_comb
    begin
        delta = $signed({{(SUM_W-9){head_cmd.neg}}, head_cmd.neg, head_cmd.move});
        big   = (!head_cmd.neg && head_cmd.move == BIG_POS_BYTE)
             || (head_cmd.neg && head_cmd.move == BIG_NEG_BYTE);
        sum_x = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_x_reg}) + delta;
        sum_y = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_y_reg}) - delta;
        new_y = clamp_pos(sum_y, cfg.y_limit);
        diff  = head_cmd.tick - last_reg;
        later = !diff[TICK_BITS-1]
             && (diff > {{(TICK_BITS-DELAY_BITS){1'b0}}, cfg.dc_delay});
        bar_edge  = {{(SUM_W-LIMIT_BITS){1'b0}}, head_cmd.top}
                  + {{(SUM_W-BAR_BITS){1'b0}}, cfg.bar_height};
        new_y_ext = {{(SUM_W-COORD_BITS){1'b0}}, new_y};
    end

    always_comb
    begin
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        xbig_next   = xbig_reg;
        lheld_next  = lheld_reg;
        rheld_next  = rheld_reg;
        drag_next   = drag_reg;
        last_next   = last_reg;
        kind_next   = kind_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        ovalid_next = ovalid_reg && out_stall;
        kind        = KIND_MOVE;
        if (pop) begin
            if (!head_cmd.is_y) begin
                pos_x_next = clamp_pos(sum_x, cfg.x_limit);
                xbig_next  = big;
            end else begin
                pos_y_next = new_y;
                if (!lheld_reg && !rheld_reg) begin
                    if (head_cmd.left)
                        lheld_next = 1'b1;
                    else if (head_cmd.right)
                        rheld_next = 1'b1;
                end else if (lheld_reg) begin
                    if (!head_cmd.left) begin
                        if (drag_reg) begin
                            kind      = KIND_NONE;
                            drag_next = 1'b0;
                        end else if (later) begin
                            kind      = KIND_LEFT;
                            last_next = head_cmd.tick;
                        end else begin
                            kind      = KIND_DOUBLE;
                            last_next = {TICK_BITS{1'b0}}
                                      - {{(TICK_BITS-DELAY_BITS){1'b0}}, cfg.dc_delay};
                        end
                        lheld_next = 1'b0;
                    end else if (new_y_ext < bar_edge) begin
                        kind      = KIND_DRAG;
                        drag_next = 1'b1;
                    end
                end else if (!head_cmd.right) begin
                    kind       = KIND_RIGHT;
                    rheld_next = 1'b0;
                end
                // A large move on either axis still updates state but sends nothing.
                if (!xbig_reg && !big) begin
                    ovalid_next = 1'b1;
                    kind_next   = kind;
                    cx_next     = to_field(pos_x_reg);
                    cy_next     = to_field(new_y);
                end
            end
        end
    end

    assign out_valid    = ovalid_reg;
    assign message_kind = kind_reg;
    assign cursor_x     = cx_reg;
    assign cursor_y     = cy_reg;

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            xbig_reg   <= 1'b0;
            lheld_reg  <= 1'b0;
            rheld_reg  <= 1'b0;
            drag_reg   <= 1'b0;
            last_reg   <= LAST_CLICK_RESET;
            ovalid_reg <= 1'b0;
        end else begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            xbig_reg   <= xbig_next;
            lheld_reg  <= lheld_next;
            rheld_reg  <= rheld_next;
            drag_reg   <= drag_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the PS/2 mouse packet decoder.
//
// The bench drives controller reads into the input channel and carries a cycle-free
// model of the decoder. That model frames packets, moves and clamps the cursor, and
// tracks the buttons. Every beat accepted on the input channel is fed to the model
// at the edge where it moves. A completed packet without a large move then adds one
// expected message to a queue. A checker pops that queue for each beat accepted on
// the output channel and compares the message kind and both cursor coordinates.
//
// The run has these parts:
//   1. Directed tests: the discarded first byte, framing errors and a resync, a double
//      click, a single click, a right press under a large move, and a title bar drag
//      with its release.
//   2. Random traffic in four parts, each with its own register setting and
//      handshake pressure. Most items are well formed packets with random content.
//      The rest are reads without data, bad headers, cut packets and stray bytes.
// Registers change only once every expected message has arrived and the pipeline
// has had time to settle.
module tb_top;
    import pmg_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    // A Y byte's message passes through the queue and then the output register;
    // the tail wait covers any work still in flight.
    localparam int TAIL_CYCLES  = 8;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BEATS  = 105;

    // The framing phases of the decoder, as the model tracks them.
    typedef enum logic [1:0] {
        PH_SYNC   = 2'd0,
        PH_HEADER = 2'd1,
        PH_XMOVE  = 2'd2,
        PH_YMOVE  = 2'd3
    } frame_phase_t;

    typedef struct {
        kind_t       kind;
        logic [10:0] x;
        logic [10:0] y;
    } mouse_msg_t;

    // Every input of the decoder holds a known value from time zero on.
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        data_ready   = 1'b0;
    logic [7:0]  data_byte    = 8'h00;
    logic [31:0] tick_now     = 32'h0;
    logic [10:0] window_top_y = 11'h0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [2:0]  message_kind;
    logic [10:0] cursor_x;
    logic [10:0] cursor_y;
    logic        cfg_write    = 1'b0;
    logic [1:0]  cfg_index    = 2'd0;
    logic [15:0] cfg_data     = 16'h0;

    // Handshake pressure of the current part, in percent per cycle.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int errors      = 0;
    int cycle_count = 0;

    // Messages the model has computed and the decoder still owes.
    mouse_msg_t pending_msgs[$];

    // The model's own copy of the decoder state and of the registers.
    frame_phase_t frame_phase;
    logic         hdr_left, hdr_right, hdr_xneg, hdr_yneg;
    logic         x_big, y_big;
    logic         left_hold, right_hold, dragging;
    logic [31:0]  click_tick;
    logic [10:0]  cur_x, cur_y;
    logic [10:0]  lim_x, lim_y;
    logic [15:0]  dbl_delay;
    logic [7:0]   bar_h;

    // Stimulus state: the running tick count and the buttons of the random traffic.
    logic [31:0]  tick_clock = 32'h0;
    logic         rand_left  = 1'b0;
    logic         rand_right = 1'b0;

    ps2_mouse_gesture_decoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .tick_now     (tick_now),
        .window_top_y (window_top_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .message_kind (message_kind),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the decoder
    // ------------------------------------------------------------------

    task automatic reset_tracker();
        frame_phase = PH_SYNC;
        hdr_left    = 1'b0;
        hdr_right   = 1'b0;
        hdr_xneg    = 1'b0;
        hdr_yneg    = 1'b0;
        x_big       = 1'b0;
        y_big       = 1'b0;
        left_hold   = 1'b0;
        right_hold  = 1'b0;
        dragging    = 1'b0;
        click_tick  = LAST_CLICK_RESET;
        cur_x       = '0;
        cur_y       = '0;
        lim_x       = X_LIMIT_RESET;
        lim_y       = Y_LIMIT_RESET;
        dbl_delay   = DELAY_RESET;
        bar_h       = BAR_RESET;
    endtask

    // A move is nine bits: the sign from the header, the low byte from the packet.
    function automatic int move9(input logic neg, input logic [7:0] b);
        return neg ? int'(b) - 256 : int'(b);
    endfunction

    function automatic logic [10:0] clamp_coord(input int v, input logic [10:0] lim);
        int ceiling;
        ceiling = int'(lim);
        if (ceiling > int'(COORD_MAX))
            ceiling = int'(COORD_MAX);
        if (v < 0)
            return '0;
        if (v > ceiling)
            return 11'(ceiling);
        return 11'(v);
    endfunction

    // Advance the model by one accepted beat and record the message it yields.
    task automatic decode_beat(input logic rdy, input logic [7:0] b, input logic [31:0] tk,
                               input logic [10:0] top_y);
        int          d;
        logic [31:0] diff;
        kind_t       kind;
        mouse_msg_t  msg;
        kind = KIND_MOVE;
        if (!rdy)
        begin
            // A read without data puts the framing back to the header.
            frame_phase = PH_HEADER;
            return;
        end
        case (frame_phase)
            PH_SYNC:
            begin
                frame_phase = PH_HEADER;
            end
            PH_HEADER:
            begin
                // A header must have bit 3 set and bit 2 clear; otherwise it is dropped.
                if (b[HDR_ONE] && !b[HDR_ZERO])
                begin
                    hdr_left    = b[HDR_LEFT];
                    hdr_right   = b[HDR_RIGHT];
                    hdr_xneg    = b[HDR_XNEG];
                    hdr_yneg    = b[HDR_YNEG];
                    frame_phase = PH_XMOVE;
                end
            end
            PH_XMOVE:
            begin
                d           = move9(hdr_xneg, b);
                x_big       = (d == 127 || d == -127);
                cur_x       = clamp_coord(int'(cur_x) + d, lim_x);
                frame_phase = PH_YMOVE;
            end
            default:
            begin
                d           = move9(hdr_yneg, b);
                y_big       = (d == 127 || d == -127);
                cur_y       = clamp_coord(int'(cur_y) - d, lim_y);
                frame_phase = PH_HEADER;
                if (!left_hold && !right_hold)
                begin
                    if (hdr_left)
                        left_hold = 1'b1;
                    else if (hdr_right)
                        right_hold = 1'b1;
                end
                else if (left_hold)
                begin
                    if (!hdr_left)
                    begin
                        if (dragging)
                        begin
                            kind     = KIND_NONE;
                            dragging = 1'b0;
                        end
                        else
                        begin
                            // The tick distance is taken modulo 2^32 and read as signed.
                            diff = tk - click_tick;
                            if (!diff[31] && diff > {16'h0, dbl_delay})
                            begin
                                kind       = KIND_LEFT;
                                click_tick = tk;
                            end
                            else
                            begin
                                kind       = KIND_DOUBLE;
                                click_tick = 32'd0 - {16'h0, dbl_delay};
                            end
                        end
                        left_hold = 1'b0;
                    end
                    else if (int'(cur_y) < int'(top_y) + int'(bar_h))
                    begin
                        kind     = KIND_DRAG;
                        dragging = 1'b1;
                    end
                end
                else if (!hdr_right)
                begin
                    kind       = KIND_RIGHT;
                    right_hold = 1'b0;
                end
                // A large move on either axis updates the state but sends nothing.
                if (!x_big && !y_big)
                begin
                    msg.kind = kind;
                    msg.x    = cur_x;
                    msg.y    = cur_y;
                    pending_msgs.push_back(msg);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Channel monitors
    // ------------------------------------------------------------------

    // Every beat that moves on the input channel goes through the model at that edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            decode_beat(data_ready, data_byte, tick_now, window_top_y);
    end

    // Every beat that moves on the output channel is checked against the oldest
    // expected message.
    always @(posedge clk)
    begin
        mouse_msg_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_msgs.size() == 0)
            begin
                $error("unexpected message: message_kind %0d cursor_x %0d cursor_y %0d",
                       message_kind, cursor_x, cursor_y);
                errors++;
            end
            else
            begin
                want = pending_msgs.pop_front();
                if (message_kind !== want.kind)
                begin
                    $error("message_kind expected %0d got %0d", want.kind, message_kind);
                    errors++;
                end
                if (cursor_x !== want.x)
                begin
                    $error("cursor_x expected %0d got %0d", want.x, cursor_x);
                    errors++;
                end
                if (cursor_y !== want.y)
                begin
                    $error("cursor_y expected %0d got %0d", want.y, cursor_y);
                    errors++;
                end
            end
        end
    end

    // The receiving side stalls at random, at the rate of the current part.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Watchdog. A run that hangs on a handshake ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ps2_mouse_gesture_decoder_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks. Each one is entered just after a rising edge and returns
    // just after one.
    // ------------------------------------------------------------------

    // Offer one read and hold it until the decoder takes it. The sender may idle
    // first. In that case valid drops for those cycles and the payload stays as is.
    task automatic send_beat(input logic rdy, input logic [7:0] b, input logic [31:0] tk,
                             input logic [10:0] top_y);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_ready   <= rdy;
        data_byte    <= b;
        tick_now     <= tk;
        window_top_y <= top_y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // One well formed packet: a header with the button and sign bits and random
    // overflow bits, then the low bytes of the nine-bit X and Y moves.
    task automatic send_packet(input logic left, input logic right, input int dx, input int dy,
                               input logic [31:0] tk, input logic [10:0] top_y);
        logic [7:0] hdr;
        logic [8:0] xv;
        logic [8:0] yv;
        xv             = 9'(dx);
        yv             = 9'(dy);
        hdr            = 8'($urandom_range(0, 3)) << 6;
        hdr[HDR_ONE]   = 1'b1;
        hdr[HDR_LEFT]  = left;
        hdr[HDR_RIGHT] = right;
        hdr[HDR_XNEG]  = xv[8];
        hdr[HDR_YNEG]  = yv[8];
        send_beat(1'b1, hdr, tk, top_y);
        send_beat(1'b1, xv[7:0], tk, top_y);
        send_beat(1'b1, yv[7:0], tk, top_y);
    endtask

    // The sender stops and waits until every expected message has arrived. Then it
    // waits out TAIL_CYCLES, so that no beat without a message is still in flight.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_msgs.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // A register write raises the enable with the index and data, then drops it again.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_X_LIMIT:  lim_x     = val[10:0];
            CFG_Y_LIMIT:  lim_y     = val[10:0];
            CFG_DC_DELAY: dbl_delay = val;
            default:      bar_h     = val[7:0];
        endcase
    endtask

    task automatic write_all_regs(input logic [15:0] xl, input logic [15:0] yl,
                                  input logic [15:0] dly, input logic [15:0] bar);
        wait_for_results();
        write_reg(CFG_X_LIMIT, xl);
        write_reg(CFG_Y_LIMIT, yl);
        write_reg(CFG_DC_DELAY, dly);
        write_reg(CFG_BAR_HEIGHT, bar);
    endtask

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------

    // Moves are mostly small so the cursor wanders. The range ends and the large
    // move values of plus and minus 127 still come up often.
    function automatic int rand_move();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return -256;
        if (r < 16)
            return 255;
        if (r < 22)
            return 127;
        if (r < 28)
            return -127;
        if (r < 40)
            return int'($urandom_range(0, 511)) - 256;
        return int'($urandom_range(0, 40)) - 20;
    endfunction

    // The tick count mostly creeps forward. Small steps make double clicks, large
    // steps make single clicks, and a full random jump now and then exercises
    // wraparound and every bit of the field.
    function automatic logic [31:0] next_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            tick_clock = tick_clock + 32'($urandom_range(0, 15));
        else if (r < 80)
            tick_clock = tick_clock + 32'($urandom_range(0, 40));
        else if (r < 95)
            tick_clock = tick_clock + 32'($urandom_range(0, 100000));
        else
            tick_clock = $urandom();
        return tick_clock;
    endfunction

    // The window top is often placed just above the cursor, so that the title bar
    // check goes both ways for many bar heights.
    function automatic logic [10:0] rand_window_top();
        int r;
        int t;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 11'($urandom_range(0, 2047));
        if (r < 75)
        begin
            t = int'(cur_y) - int'($urandom_range(0, 30));
            return (t < 0) ? 11'd0 : 11'(t);
        end
        return 11'd0;
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // The first data byte after reset is thrown away, even if it looks like a header.
    task automatic test_first_byte_discard();
        send_beat(1'b1, 8'h09, 32'h0, 11'd0);
    endtask

    // A header with bit 3 clear and one with bit 2 set are both dropped. A good
    // header followed by a read without data starts framing over.
    task automatic test_framing_errors();
        send_beat(1'b1, 8'h00, 32'h0, 11'd0);
        send_beat(1'b1, 8'h0C, 32'h0, 11'd0);
        send_beat(1'b1, 8'h09, 32'h0, 11'd0);
        send_beat(1'b0, 8'hFF, 32'h0, 11'd0);
    endtask

    // The last click time starts twenty ticks back, so a release at tick zero is
    // just inside the default delay. The moves use both ends of the nine-bit range.
    task automatic test_double_click();
        send_packet(1'b1, 1'b0, 255, -256, 32'h0, 11'd0);
        send_packet(1'b0, 1'b0, -256, 255, 32'h0, 11'd0);
    endtask

    task automatic test_single_click();
        send_packet(1'b1, 1'b0, 10, -5, 32'd990, 11'd0);
        send_packet(1'b0, 1'b0, -3, 2, 32'd1000, 11'd0);
    endtask

    // The press packet carries a large X move. It changes the state but sends no
    // message.
    task automatic test_right_press();
        send_packet(1'b0, 1'b1, 127, 0, 32'hFFFF_FFFF, 11'd2047);
        send_packet(1'b0, 1'b0, 1, 1, 32'hFFFF_FFFF, 11'd2047);
    endtask

    // The press is hidden by a large Y move. The left hold with the window top at
    // the bottom of the screen is a drag, and the release after it is a drag release.
    task automatic test_drag_release();
        send_packet(1'b1, 1'b0, 0, -127, 32'd5000, 11'd0);
        send_packet(1'b1, 1'b0, 4, 4, 32'd5001, 11'd2047);
        send_packet(1'b0, 1'b0, -4, -4, 32'd5002, 11'd2047);
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------

    // About four in five items are well formed packets with buttons that stick
    // between packets. Only their beats count toward the length of the part.
    task automatic test_random_traffic(input int sidle, input int rstall, input int n_beats);
        int         packet_beats;
        int         r;
        logic [7:0] b;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        packet_beats   = 0;
        while (packet_beats < n_beats)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                if ($urandom_range(0, 99) < 35)
                    rand_left = ~rand_left;
                if ($urandom_range(0, 99) < 25)
                    rand_right = ~rand_right;
                send_packet(rand_left, rand_right, rand_move(), rand_move(), next_tick(),
                            rand_window_top());
                packet_beats += 3;
            end
            else if (r < 86)
            begin
                send_beat(1'b0, 8'($urandom()), next_tick(), rand_window_top());
            end
            else if (r < 92)
            begin
                b = 8'($urandom());
                if ($urandom_range(0, 1))
                    b[HDR_ONE] = 1'b0;
                else
                    b[HDR_ZERO] = 1'b1;
                send_beat(1'b1, b, next_tick(), rand_window_top());
            end
            else if (r < 96)
            begin
                // Cut packet: a header and an X move, then a read without data.
                send_beat(1'b1, 8'h08 | 8'($urandom_range(0, 3)), next_tick(), 11'd0);
                send_beat(1'b1, 8'($urandom()), next_tick(), 11'd0);
                send_beat(1'b0, 8'($urandom()), next_tick(), 11'd0);
            end
            else
            begin
                send_beat(1'b1, 8'($urandom()), next_tick(), rand_window_top());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_tracker();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_byte_discard();
        test_framing_errors();
        test_double_click();
        test_single_click();
        test_right_press();
        test_drag_release();
        tick_clock = 32'd6000;

        // Register defaults, no idling on either side.
        test_random_traffic(0, 0, PHASE_BEATS);

        // Largest limits, zero delay and the tallest bar, with the sender idling.
        write_all_regs(16'd2047, 16'd2047, 16'd0, 16'd255);
        test_random_traffic(57, 0, PHASE_BEATS);

        // Cursor pinned at the origin, longest delay and no title bar, with the
        // receiver stalling.
        write_all_regs(16'd0, 16'd0, 16'd65535, 16'd0);
        test_random_traffic(0, 57, PHASE_BEATS);

        // Random setting, both sides idling now and then.
        write_all_regs(16'($urandom_range(100, 2047)), 16'($urandom_range(100, 2047)),
                       16'($urandom_range(0, 200)), 16'($urandom_range(0, 255)));
        test_random_traffic(17, 17, PHASE_BEATS);

        wait_for_results();
        if (pending_msgs.size() != 0)
        begin
            $error("%0d expected messages never arrived", pending_msgs.size());
            errors++;
        end
        if (errors == 0)
            $display("ps2_mouse_gesture_decoder_top: match");
        else
            $display("ps2_mouse_gesture_decoder_top: mismatch");
        $finish;
    end

endmodule
